// ===== src/lca_binary_lifting_unit_assert.svh =====
// Assertion macros for the RTL files of the lowest common ancestor unit.
// Define ASSERT_OFF to compile the assertions out.
`ifndef LCA_BINARY_LIFTING_UNIT_ASSERT_SVH
`define LCA_BINARY_LIFTING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define LCABL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition never holds at a rising clock edge outside reset.
`define LCABL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define LCABL_ASSERT(lbl, clk, rstn, prop, msg)
`define LCABL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== src/lcabl_pkg.sv =====
package lcabl_pkg;

    localparam int NODE_W      = 16;
    localparam int DEPTH_W     = 16;
    localparam int NODES_DEF   = 65536;
    localparam int LEVELS_DEF  = 16;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_DEPTH,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_DEPTH,
        ST_Q_LIFT_RD,
        ST_Q_LIFT_WAIT,
        ST_Q_CMP,
        ST_Q_SRCH_RD,
        ST_Q_SRCH_WAIT,
        ST_Q_FIN_RD,
        ST_Q_FIN_WAIT,
        ST_OUT
    } lcabl_state_t;

endpackage

// ===== src/lcabl_store.sv =====
module lcabl_store
    import lcabl_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF,
    localparam int ID_W  = $clog2(NODES),
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               aclk,
    // ancestor table: two read ports sharing one level, one write port
    input  logic [LVL_W-1:0]   lift_rd_lvl,
    input  logic [ID_W-1:0]    lift_rd_a,
    input  logic [ID_W-1:0]    lift_rd_b,
    output logic [NODE_W-1:0]  lift_rdata_a,
    output logic [NODE_W-1:0]  lift_rdata_b,
    input  logic               lift_we,
    input  logic [LVL_W-1:0]   lift_wr_lvl,
    input  logic [ID_W-1:0]    lift_wr_idx,
    input  logic [NODE_W-1:0]  lift_wr_data,
    // depth table: two read ports, one write port
    input  logic [ID_W-1:0]    depth_rd_a,
    input  logic [ID_W-1:0]    depth_rd_b,
    output logic [DEPTH_W-1:0] depth_rdata_a,
    output logic [DEPTH_W-1:0] depth_rdata_b,
    input  logic               depth_we,
    input  logic [ID_W-1:0]    depth_wr_idx,
    input  logic [DEPTH_W-1:0] depth_wr_data
);

    localparam int LIFT_DEPTH = LEVELS * (2 ** ID_W);

    logic [NODE_W-1:0]  lift_mem  [LIFT_DEPTH];
    logic [DEPTH_W-1:0] depth_mem [2 ** ID_W];

    logic [NODE_W-1:0]  lift_q_a_reg;
    logic [NODE_W-1:0]  lift_q_b_reg;
    logic [DEPTH_W-1:0] depth_q_a_reg;
    logic [DEPTH_W-1:0] depth_q_b_reg;
    logic               lift_zero_a_reg;
    logic               lift_zero_b_reg;
    logic               depth_zero_a_reg;
    logic               depth_zero_b_reg;

    always_ff @(posedge aclk) begin
        if (lift_we) begin
            lift_mem[{lift_wr_lvl, lift_wr_idx}] <= lift_wr_data;
        end
        lift_q_a_reg <= lift_mem[{lift_rd_lvl, lift_rd_a}];
        lift_q_b_reg <= lift_mem[{lift_rd_lvl, lift_rd_b}];
    end

    always_ff @(posedge aclk) begin
        if (depth_we) begin
            depth_mem[depth_wr_idx] <= depth_wr_data;
        end
        depth_q_a_reg <= depth_mem[depth_rd_a];
        depth_q_b_reg <= depth_mem[depth_rd_b];
    end

    // node 0 is never stored: force its depth and ancestors to zero
    always_ff @(posedge aclk) begin
        lift_zero_a_reg  <= (lift_rd_a == '0);
        lift_zero_b_reg  <= (lift_rd_b == '0);
        depth_zero_a_reg <= (depth_rd_a == '0);
        depth_zero_b_reg <= (depth_rd_b == '0);
    end

    assign lift_rdata_a  = lift_zero_a_reg  ? '0 : lift_q_a_reg;
    assign lift_rdata_b  = lift_zero_b_reg  ? '0 : lift_q_b_reg;
    assign depth_rdata_a = depth_zero_a_reg ? '0 : depth_q_a_reg;
    assign depth_rdata_b = depth_zero_b_reg ? '0 : depth_q_b_reg;

endmodule

// ===== src/lca_binary_lifting_unit.sv =====
// Lowest common ancestor unit, binary lifting over a table of 2^i-th ancestors.
// Input channel (s_): one transaction per item. s_tuser selects the kind:
// add a node (s_tdata low half = new node, high half = its parent, 0 for a
// root) or query (s_tdata low half and high half = the two nodes). Nodes must
// be added parent-first; node 0 is the sentinel with depth 0 and ancestor 0.
// Output channel (m_): one transaction per query, m_tdata = the ancestor.
// Adds give no output transaction.
// A query whose nodes already meet after the first lift skips the ancestor
// search. The ancestor walk is a chain of dependent reads from the ancestor
// memory, each level an address and then registered read data. One item is in
// work at a time; s_tready is high only when the unit is free.
// The result sits in an output register, so a stalled receiver holds only that
// transaction; the unit accepts further adds meanwhile, and a query that
// finishes while the register is still full waits for it to drain.
// Reset clears the control state only; table contents are undefined until
// written, so no clearing pass runs and the unit is ready right after reset.
`include "lca_binary_lifting_unit_assert.svh"

module lca_binary_lifting_unit
    import lcabl_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*NODE_W-1:0] s_tdata,   // [15:0] node_a, [31:16] node_b
    input  logic                s_tuser,   // [0] kind: 0 add, 1 query
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [NODE_W-1:0]   m_tdata    // [15:0] ancestor
);

    localparam int ID_W  = $clog2(NODES);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

    lcabl_state_t state_reg, state_next;

    logic [NODE_W-1:0]  u_reg, u_next;      // add: new node; query: shallower node
    logic [NODE_W-1:0]  v_reg, v_next;      // add: current ancestor; query: deeper node
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [DEPTH_W-1:0] diff_reg, diff_next;
    logic [NODE_W-1:0]  res_reg, res_next;
    logic [NODE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [NODE_W-1:0]  in_a_id;
    logic [NODE_W-1:0]  in_b_id;

    logic [LVL_W-1:0]   lift_rd_lvl;
    logic [ID_W-1:0]    lift_rd_a;
    logic [ID_W-1:0]    lift_rd_b;
    logic [NODE_W-1:0]  lift_rdata_a;
    logic [NODE_W-1:0]  lift_rdata_b;
    logic               lift_we;
    logic [LVL_W-1:0]   lift_wr_lvl;
    logic [NODE_W-1:0]  lift_wr_data;
    logic [DEPTH_W-1:0] depth_rdata_a;
    logic [DEPTH_W-1:0] depth_rdata_b;
    logic               depth_we;
    logic [DEPTH_W-1:0] depth_wr_data;

    // map ids beyond the table onto the sentinel
    assign in_a_id = (32'(s_tdata[NODE_W-1:0]) < NODES) ? s_tdata[NODE_W-1:0] : '0;
    assign in_b_id = (32'(s_tdata[2*NODE_W-1:NODE_W]) < NODES)
                   ? s_tdata[2*NODE_W-1:NODE_W] : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lcabl_store #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_store (
        .aclk          (aclk),
        .lift_rd_lvl   (lift_rd_lvl),
        .lift_rd_a     (lift_rd_a),
        .lift_rd_b     (lift_rd_b),
        .lift_rdata_a  (lift_rdata_a),
        .lift_rdata_b  (lift_rdata_b),
        .lift_we       (lift_we),
        .lift_wr_lvl   (lift_wr_lvl),
        .lift_wr_idx   (ID_W'(u_reg)),
        .lift_wr_data  (lift_wr_data),
        .depth_rd_a    (ID_W'(in_a_id)),
        .depth_rd_b    (ID_W'(in_b_id)),
        .depth_rdata_a (depth_rdata_a),
        .depth_rdata_b (depth_rdata_b),
        .depth_we      (depth_we),
        .depth_wr_idx  (ID_W'(u_reg)),
        .depth_wr_data (depth_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg       <= u_next;
        v_reg       <= v_next;
        lvl_reg     <= lvl_next;
        diff_reg    <= diff_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        lvl_next      = lvl_reg;
        diff_next     = diff_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        lift_rd_lvl   = lvl_reg;
        lift_rd_a     = ID_W'(u_reg);
        lift_rd_b     = ID_W'(v_reg);
        lift_we       = 1'b0;
        lift_wr_lvl   = lvl_reg;
        lift_wr_data  = lift_rdata_a;
        depth_we      = 1'b0;
        depth_wr_data = (depth_rdata_b == '1) ? depth_rdata_b : depth_rdata_b + 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                // depth reads of both input ids go out in this cycle
                if (s_tvalid) begin
                    u_next = in_a_id;
                    v_next = in_b_id;
                    if (s_tuser == KIND_QUERY) begin
                        state_next = ST_Q_DEPTH;
                    end else if (in_a_id != '0) begin
                        state_next = ST_ADD_DEPTH;
                    end
                end
            end
            ST_ADD_DEPTH: begin
                // store depth (saturating) and the parent as level 0
                depth_we     = 1'b1;
                lift_we      = 1'b1;
                lift_wr_lvl  = '0;
                lift_wr_data = v_reg;
                lvl_next     = LVL_W'(1);
                state_next   = (LEVELS > 1) ? ST_ADD_RD : ST_IDLE;
            end
            ST_ADD_RD: begin
                lift_rd_lvl = lvl_reg - LVL_W'(1);
                lift_rd_a   = ID_W'(v_reg);
                state_next  = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                lift_we      = 1'b1;
                lift_wr_data = lift_rdata_a;
                v_next       = lift_rdata_a;
                if (lvl_reg == LVL_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_ADD_RD;
                end
            end
            ST_Q_DEPTH: begin
                // keep the deeper node in v
                if (depth_rdata_a > depth_rdata_b) begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = depth_rdata_a - depth_rdata_b;
                end else begin
                    diff_next = depth_rdata_b - depth_rdata_a;
                end
                lvl_next   = '0;
                state_next = ST_Q_LIFT_RD;
            end
            ST_Q_LIFT_RD: begin
                state_next = ST_Q_LIFT_WAIT;
            end
            ST_Q_LIFT_WAIT: begin
                if (diff_reg[0]) begin
                    v_next = lift_rdata_b;
                end
                diff_next = diff_reg >> 1;
                if (lvl_reg == LVL_LAST) begin
                    state_next = ST_Q_CMP;
                end else begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_Q_LIFT_RD;
                end
            end
            ST_Q_CMP: begin
                if (u_reg == v_reg) begin
                    res_next   = u_reg;
                    state_next = ST_OUT;
                end else begin
                    lvl_next   = LVL_LAST;
                    state_next = ST_Q_SRCH_RD;
                end
            end
            ST_Q_SRCH_RD: begin
                state_next = ST_Q_SRCH_WAIT;
            end
            ST_Q_SRCH_WAIT: begin
                // advance both nodes while their ancestors differ
                if (lift_rdata_a != lift_rdata_b) begin
                    u_next = lift_rdata_a;
                    v_next = lift_rdata_b;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_Q_FIN_RD;
                end else begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_Q_SRCH_RD;
                end
            end
            ST_Q_FIN_RD: begin
                lift_rd_lvl = '0;
                state_next  = ST_Q_FIN_WAIT;
            end
            ST_Q_FIN_WAIT: begin
                res_next   = lift_rdata_a;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LCABL_ASSERT(a_valid_from_out, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT), "result loaded outside output state")
    `LCABL_ASSERT(a_lift_we_in_add, aclk, aresetn, lift_we |-> (state_reg == ST_ADD_DEPTH || state_reg == ST_ADD_WR), "ancestor write outside add")
    `LCABL_ASSERT(a_lvl_in_range, aclk, aresetn, 32'(lvl_reg) < LEVELS || state_reg == ST_IDLE, "level counter out of range")
    `LCABL_ASSERT(a_depth_we_then, aclk, aresetn, depth_we |=> (state_reg == ST_ADD_RD || state_reg == ST_IDLE), "depth write not followed by level fill")
    `LCABL_ASSERT_NEVER(a_query_no_write, aclk, aresetn, depth_we && state_reg != ST_ADD_DEPTH, "depth write outside add")

endmodule
